@@ src/redundant_ecu_fault_voter_top_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the fault voter
// Concurrent checks clocked on i_clk, disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef REDUNDANT_ECU_FAULT_VOTER_TOP_MACROS_SVH
`define REDUNDANT_ECU_FAULT_VOTER_TOP_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define RFV_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("fault voter check failed");
// next-cycle implication
`define RFV_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("fault voter check failed");
`else
`define RFV_ASSERT_NOW(label, ante, cons)
`define RFV_ASSERT_NEXT(label, ante, cons)
`endif

`endif

@@ src/rfv_pkg.sv @@
// ----------------------------------------------------------------------------
// Fault voter package
// Shared codes, types and register indexes.
// ----------------------------------------------------------------------------
package rfv_pkg;

    localparam int unsigned LIMIT_W = 10;
    localparam int unsigned SPEED_W = 16;

    // configuration register indexes
    localparam logic CFG_INITIAL_UNIT = 1'b0;
    localparam logic CFG_STOP_LIMIT   = 1'b1;

    typedef enum logic [2:0] {
        UNIT_MAIN    = 3'd0,
        UNIT_SUB     = 3'd1,
        UNIT_SUP     = 3'd2,
        UNIT_UNKNOWN = 3'd3,
        UNIT_NONE    = 3'd4
    } t_unit;

    typedef enum logic [2:0] {
        MODE_NORMAL    = 3'd0,
        MODE_SUPSTOP   = 3'd1,
        MODE_COMFORT   = 3'd2,
        MODE_SUCCEEDED = 3'd3,
        MODE_FAILED    = 3'd4
    } t_mode;

    typedef struct packed {
        logic [2:0]               self_alarm;
        logic [2:0]               self_recov;
        logic [2:0]               ext_alarm_a;
        logic [2:0]               ext_alarm_b;
        logic [1:0]               switched_unit;
        logic signed [SPEED_W-1:0] speed;
    } t_item;

    typedef struct packed {
        t_unit fault;
        t_unit stopper;
        logic  csas;
        logic  ext_found;
        logic  stopped;
    } t_decision;

    typedef struct packed {
        t_mode mode;
        t_unit fault_unit;
        t_unit stop_unit;
        logic  pending;
    } t_voter_state;

endpackage

@@ src/rfv_in_if.sv @@
// ----------------------------------------------------------------------------
// Fault voter input channel
// One beat carries one evaluation tick.
// ----------------------------------------------------------------------------
interface rfv_in_if;
    logic               valid;
    logic               ready;
    logic [2:0]         self_alarm;
    logic [2:0]         self_recov;
    logic [2:0]         ext_alarm_a;
    logic [2:0]         ext_alarm_b;
    logic [1:0]         switched_unit;
    logic signed [15:0] speed;

    modport source (
        output valid, self_alarm, self_recov, ext_alarm_a, ext_alarm_b,
               switched_unit, speed,
        input  ready
    );
    modport sink (
        input  valid, self_alarm, self_recov, ext_alarm_a, ext_alarm_b,
               switched_unit, speed,
        output ready
    );
endinterface

@@ src/rfv_out_if.sv @@
// ----------------------------------------------------------------------------
// Fault voter result channel
// One beat carries the voter state after one tick.
// ----------------------------------------------------------------------------
interface rfv_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] mode;
    logic [2:0] faulty_unit;
    logic [2:0] stopping_unit;
    logic       stop_after_switch;
    logic       external_found;
    logic       illegal_request;

    modport source (
        output valid, mode, faulty_unit, stopping_unit, stop_after_switch,
               external_found, illegal_request,
        input  ready
    );
    modport sink (
        input  valid, mode, faulty_unit, stopping_unit, stop_after_switch,
               external_found, illegal_request,
        output ready
    );
endinterface

@@ src/rfv_decide.sv @@
// ----------------------------------------------------------------------------
// Fault voter decision
// Per-unit error status and the stop operation for one tick.
// ----------------------------------------------------------------------------
module rfv_decide (
    input  rfv_pkg::t_item                 i_item,
    input  logic                           i_initial_unit,
    input  logic [rfv_pkg::LIMIT_W-1:0]    i_stop_limit,
    output rfv_pkg::t_decision             o_dec
);

    logic [2:0] ext_err;
    logic [2:0] ext_stop, ext_switch;
    logic [2:0] self_stop, self_switch;
    logic [2:0] mask, stop_v, switch_v;
    logic       init_sel, multi, stop_hit, switch_hit;
    rfv_pkg::t_unit single_unit;

    assign ext_err  = i_item.ext_alarm_a & i_item.ext_alarm_b;
    assign init_sel = (i_item.switched_unit == {1'b0, i_initial_unit});

    always_comb begin
        for (int u = 0; u < 3; u++) begin
            if (i_item.switched_unit == 2'(u)) begin
                ext_stop[u]    = 1'b1;
                ext_switch[u]  = 1'b1;
                self_stop[u]   = ~i_item.self_recov[u];
                self_switch[u] = ~i_item.self_recov[u];
            end else begin
                ext_stop[u]    = init_sel;
                ext_switch[u]  = 1'b0;
                self_stop[u]   = init_sel;
                self_switch[u] = 1'b0;
            end
        end
    end

    // external monitoring takes precedence over self reports
    assign mask       = (ext_err != 3'd0) ? ext_err    : i_item.self_alarm;
    assign stop_v     = (ext_err != 3'd0) ? ext_stop   : self_stop;
    assign switch_v   = (ext_err != 3'd0) ? ext_switch : self_switch;
    assign multi      = ((mask & (mask - 3'd1)) != 3'd0);
    assign stop_hit   = |(stop_v & mask);
    assign switch_hit = |(switch_v & mask);

    always_comb begin
        case (mask)
            3'b001:  single_unit = rfv_pkg::UNIT_MAIN;
            3'b010:  single_unit = rfv_pkg::UNIT_SUB;
            3'b100:  single_unit = rfv_pkg::UNIT_SUP;
            default: single_unit = rfv_pkg::UNIT_UNKNOWN;
        endcase
    end

    always_comb begin
        o_dec.ext_found = (ext_err != 3'd0);
        // speed is signed, limit is unsigned: compare on 17 bits
        o_dec.stopped   = ($signed({i_item.speed[15], i_item.speed}) <
                           $signed({7'd0, i_stop_limit}));
        o_dec.fault     = rfv_pkg::UNIT_NONE;
        o_dec.stopper   = rfv_pkg::UNIT_NONE;
        o_dec.csas      = 1'b0;
        if (mask == 3'd0) begin
            o_dec.fault = rfv_pkg::UNIT_NONE;
        end else if (multi) begin
            o_dec.fault   = rfv_pkg::UNIT_UNKNOWN;
            o_dec.stopper = rfv_pkg::UNIT_SUP;
        end else begin
            o_dec.fault = single_unit;
            if (!stop_hit) begin
                o_dec.stopper = rfv_pkg::UNIT_NONE;
            end else if (switch_hit) begin
                o_dec.stopper = rfv_pkg::UNIT_SUP;
                o_dec.csas    = 1'b1;
            end else if (i_item.switched_unit != 2'd3) begin
                o_dec.stopper = rfv_pkg::t_unit'({1'b0, i_item.switched_unit});
            end
        end
    end

endmodule

@@ src/rfv_voter.sv @@
// ----------------------------------------------------------------------------
// Fault voter state machine
// Five-mode voter with held fault and stopping units.
// ----------------------------------------------------------------------------
module rfv_voter (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_adv,
    input  rfv_pkg::t_decision    i_dec,
    input  logic                  i_initial_unit,
    output rfv_pkg::t_voter_state o_state,
    output rfv_pkg::t_voter_state o_next,
    output logic                  o_illegal
);

    rfv_pkg::t_voter_state r_state, n_state;
    rfv_pkg::t_unit        init_unit;
    logic                  n_illegal;

    assign init_unit = rfv_pkg::t_unit'({2'b00, i_initial_unit});

    always_comb begin
        n_state   = r_state;
        n_illegal = 1'b0;
        case (r_state.mode)
            rfv_pkg::MODE_NORMAL: begin
                if (i_dec.fault != rfv_pkg::UNIT_NONE) begin
                    if (i_dec.stopper == rfv_pkg::UNIT_SUP) begin
                        n_state.mode       = rfv_pkg::MODE_SUPSTOP;
                        n_state.fault_unit = i_dec.fault;
                        n_state.pending    = i_dec.csas;
                    end else if (i_dec.stopper != rfv_pkg::UNIT_NONE) begin
                        if (i_dec.stopper != init_unit) begin
                            n_illegal = 1'b1;
                        end else begin
                            n_state.mode       = rfv_pkg::MODE_COMFORT;
                            n_state.fault_unit = i_dec.fault;
                            n_state.pending    = 1'b0;
                        end
                    end
                end
            end
            rfv_pkg::MODE_SUPSTOP: begin
                if (i_dec.stopped) begin
                    if (r_state.pending) begin
                        n_state.pending = 1'b0;
                        if (r_state.fault_unit == rfv_pkg::UNIT_MAIN) begin
                            n_state.stop_unit = rfv_pkg::UNIT_SUB;
                            n_state.mode      = rfv_pkg::MODE_COMFORT;
                        end else if (r_state.fault_unit == rfv_pkg::UNIT_SUB) begin
                            n_state.stop_unit = rfv_pkg::UNIT_MAIN;
                            n_state.mode      = rfv_pkg::MODE_COMFORT;
                        end else begin
                            n_state.mode = rfv_pkg::MODE_FAILED;
                        end
                    end else begin
                        n_state.mode = rfv_pkg::MODE_SUCCEEDED;
                    end
                end else if (i_dec.fault == rfv_pkg::UNIT_NONE) begin
                    n_state.mode       = rfv_pkg::MODE_NORMAL;
                    n_state.fault_unit = rfv_pkg::UNIT_NONE;
                    n_state.stop_unit  = rfv_pkg::UNIT_NONE;
                    n_state.pending    = 1'b0;
                end else if (i_dec.stopper == rfv_pkg::UNIT_NONE) begin
                    n_state = r_state;
                end else if (i_dec.stopper != rfv_pkg::UNIT_SUP) begin
                    if (i_dec.stopper != init_unit) begin
                        n_illegal = 1'b1;
                    end else begin
                        n_state.mode       = rfv_pkg::MODE_COMFORT;
                        n_state.fault_unit = i_dec.fault;
                        n_state.stop_unit  = i_dec.stopper;
                        n_state.pending    = 1'b0;
                    end
                end else begin
                    n_state.fault_unit = i_dec.fault;
                    if (!i_dec.csas) begin
                        n_state.pending = 1'b0;
                    end
                end
            end
            rfv_pkg::MODE_COMFORT: begin
                if (i_dec.stopped) begin
                    n_state.mode = rfv_pkg::MODE_SUCCEEDED;
                end else if (i_dec.fault == rfv_pkg::UNIT_NONE) begin
                    n_state.mode       = rfv_pkg::MODE_NORMAL;
                    n_state.fault_unit = rfv_pkg::UNIT_NONE;
                    n_state.stop_unit  = rfv_pkg::UNIT_NONE;
                    n_state.pending    = 1'b0;
                end else if (i_dec.stopper == rfv_pkg::UNIT_NONE) begin
                    n_state = r_state;
                end else if (i_dec.stopper == rfv_pkg::UNIT_SUP) begin
                    n_state.mode       = rfv_pkg::MODE_SUPSTOP;
                    n_state.fault_unit = i_dec.fault;
                    n_state.stop_unit  = rfv_pkg::UNIT_SUP;
                    n_state.pending    = i_dec.csas;
                end else if (i_dec.stopper != r_state.stop_unit) begin
                    if (i_dec.stopper != init_unit) begin
                        n_illegal = 1'b1;
                    end else begin
                        n_state.stop_unit = i_dec.stopper;
                    end
                end
            end
            default: begin
                // succeeded and failed hold until reset
                n_state = r_state;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.mode       <= rfv_pkg::MODE_NORMAL;
            r_state.fault_unit <= rfv_pkg::UNIT_NONE;
            r_state.stop_unit  <= rfv_pkg::UNIT_NONE;
            r_state.pending    <= 1'b0;
        end else if (i_adv) begin
            r_state <= n_state;
        end
    end

    assign o_state   = r_state;
    assign o_next    = n_state;
    assign o_illegal = n_illegal;

endmodule

@@ src/redundant_ecu_fault_voter_top.sv @@
// ----------------------------------------------------------------------------
// Redundant ECU fault voter, top level
// Path: input beat -> input reg (r_item) -> result reg (r_res_state) -> result beat.
// Throughput: one tick per cycle, except while a held result waits for o_result.ready.
// Reset: synchronous active-low i_rst_n; voter normal, units none, regs default.
// ----------------------------------------------------------------------------
`include "redundant_ecu_fault_voter_top_macros.svh"

module redundant_ecu_fault_voter_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_idx,
    input  logic [rfv_pkg::LIMIT_W-1:0] i_cfg_data,
    rfv_in_if.sink                      i_item,
    rfv_out_if.source                   o_result
);

    // Pipeline: an input beat lands in r_item; the stage advances when the
    // result register is empty or being drained. The voter state updates on
    // the same edge that loads the result, so results leave in tick order.

    logic                        r_initial_unit;
    logic [rfv_pkg::LIMIT_W-1:0] r_stop_limit;

    logic                  r_in_valid;
    rfv_pkg::t_item        r_item;
    logic                  r_out_valid;
    rfv_pkg::t_voter_state r_res_state;
    logic                  r_res_ext;
    logic                  r_res_illegal;

    logic                  adv;
    rfv_pkg::t_decision    dec;
    rfv_pkg::t_voter_state cur_state, nxt_state;
    logic                  illegal;

    assign adv          = r_in_valid && (!r_out_valid || o_result.ready);
    assign i_item.ready = !r_in_valid || adv;

    // config writes must only happen while idle; the block itself does not enforce this
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_initial_unit <= 1'b0;
            r_stop_limit   <= rfv_pkg::LIMIT_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                rfv_pkg::CFG_INITIAL_UNIT: r_initial_unit <= i_cfg_data[0];
                rfv_pkg::CFG_STOP_LIMIT:   r_stop_limit   <= i_cfg_data;
                default:                   r_stop_limit   <= r_stop_limit;
            endcase
        end
    end

    // handshake control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_item.ready) begin
                r_in_valid <= i_item.valid;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_item.self_alarm    <= i_item.self_alarm;
            r_item.self_recov    <= i_item.self_recov;
            r_item.ext_alarm_a   <= i_item.ext_alarm_a;
            r_item.ext_alarm_b   <= i_item.ext_alarm_b;
            r_item.switched_unit <= i_item.switched_unit;
            r_item.speed         <= i_item.speed;
        end
        if (adv) begin
            r_res_state   <= nxt_state;
            r_res_ext     <= dec.ext_found;
            r_res_illegal <= illegal;
        end
    end

    rfv_decide u_decide (
        .i_item         (r_item),
        .i_initial_unit (r_initial_unit),
        .i_stop_limit   (r_stop_limit),
        .o_dec          (dec)
    );

    rfv_voter u_voter (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_adv          (adv),
        .i_dec          (dec),
        .i_initial_unit (r_initial_unit),
        .o_state        (cur_state),
        .o_next         (nxt_state),
        .o_illegal      (illegal)
    );

    assign o_result.valid             = r_out_valid;
    assign o_result.mode              = r_res_state.mode;
    assign o_result.faulty_unit       = r_res_state.fault_unit;
    assign o_result.stopping_unit     = r_res_state.stop_unit;
    assign o_result.stop_after_switch = r_res_state.pending;
    assign o_result.external_found    = r_res_ext;
    assign o_result.illegal_request   = r_res_illegal;

    // terminal modes never leave
    `RFV_ASSERT_NEXT(a_succeeded_holds, cur_state.mode == rfv_pkg::MODE_SUCCEEDED, cur_state.mode == rfv_pkg::MODE_SUCCEEDED)
    `RFV_ASSERT_NEXT(a_failed_holds, cur_state.mode == rfv_pkg::MODE_FAILED, cur_state.mode == rfv_pkg::MODE_FAILED)
    // an illegal request leaves the voter untouched
    `RFV_ASSERT_NEXT(a_illegal_keeps_state, adv && illegal, cur_state == $past(cur_state))
    // normal mode never holds a fault unit
    `RFV_ASSERT_NOW(a_normal_no_fault, cur_state.mode == rfv_pkg::MODE_NORMAL, cur_state.fault_unit == rfv_pkg::UNIT_NONE)

endmodule
